// ===== rtl/lds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lds_pkg
// Shared types and constants of the LU decompose and solve block.
// ----------------------------------------------------------------------------
package lds_pkg;

   localparam int MAX_ORDER_DEF = 8;
   localparam int ORDER_DEF     = 8;
   localparam int DIV_BITS      = 48;
   localparam int ACC_W         = 56;

   localparam logic KIND_MATRIX = 1'b0;
   localparam logic KIND_RHS    = 1'b1;

   localparam logic RK_STATUS   = 1'b0;
   localparam logic RK_SOLUTION = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SINGULAR = 2'd1;
   localparam logic [1:0] STATUS_NOFACTOR = 2'd2;

   typedef struct packed {
      logic                valid;
      logic [DIV_BITS-1:0] num;
      logic [31:0]         rem;
      logic [DIV_BITS-1:0] quo;
      logic [31:0]         den;
      logic                neg;
      logic                zden;
      logic                asign;
      logic                azero;
   } div_word_type;

endpackage

// ===== rtl/lds_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lds_div_cell
// One restoring division step: takes one numerator bit, passes the word on.
// ----------------------------------------------------------------------------
module lds_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  lds_pkg::div_word_type word_i,
   output lds_pkg::div_word_type word_o
);

   lds_pkg::div_word_type word_ff, word_in;
   logic [32:0] trial;
   logic [32:0] diff;
   logic        ge;

   always_comb begin
      trial = {word_i.rem, word_i.num[lds_pkg::DIV_BITS-1]};
      diff  = trial - {1'b0, word_i.den};
      ge    = (trial >= {1'b0, word_i.den});
      word_in     = word_i;
      word_in.rem = ge ? diff[31:0] : trial[31:0];
      word_in.num = {word_i.num[lds_pkg::DIV_BITS-2:0], 1'b0};
      word_in.quo = {word_i.quo[lds_pkg::DIV_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else begin
         word_ff <= word_in;
      end
   end

   assign word_o = word_ff;

endmodule

// ===== rtl/lds_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lds_divider
// Q16.16 quotient (a << 16) / p, rounded half away from zero, saturated.
// ----------------------------------------------------------------------------
module lds_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [31:0] a,
   input  logic [31:0] p,
   output logic [31:0] q,
   output logic        done
);

   localparam int NB = lds_pkg::DIV_BITS;

   lds_pkg::div_word_type chain [NB+1];
   lds_pkg::div_word_type s0_ff, s0_in;
   logic [31:0] mag_a, mag_p;
   logic [NB-1:0] quo;
   logic [31:0] q_ff, q_in;
   logic        done_ff;

   always_comb begin
      mag_a = a[31] ? (~a + 32'd1) : a;
      mag_p = p[31] ? (~p + 32'd1) : p;
      s0_in.valid = go;
      s0_in.num   = {mag_a, 16'd0} + NB'(mag_p >> 1);
      s0_in.rem   = 32'd0;
      s0_in.quo   = '0;
      s0_in.den   = mag_p;
      s0_in.neg   = a[31] ^ p[31];
      s0_in.zden  = (p == 32'd0);
      s0_in.asign = a[31];
      s0_in.azero = (a == 32'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
      end else begin
         s0_ff <= s0_in;
      end
   end

   assign chain[0] = s0_ff;

   for (genvar g = 0; g < NB; g++) begin : g_cell
      lds_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .word_i (chain[g]),
         .word_o (chain[g+1])
      );
   end

   always_comb begin
      quo = chain[NB].quo;
      if (chain[NB].zden) begin
         q_in = chain[NB].azero ? 32'd0 : (chain[NB].asign ? 32'h8000_0000 : 32'h7fff_ffff);
      end else if (chain[NB].neg) begin
         q_in = (quo > NB'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000 : (~quo[31:0] + 32'd1);
      end else begin
         q_in = (quo > NB'(32'h7fff_ffff)) ? 32'h7fff_ffff : quo[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= chain[NB].valid;
      end
      q_ff <= q_in;
   end

   assign q    = q_ff;
   assign done = done_ff;

endmodule

// ===== rtl/lu_decompose_and_solve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_decompose_and_solve
// Crout LU with scaled partial pivoting and triangular solve, signed Q16.16.
// ----------------------------------------------------------------------------
// Words enter on start/req_kind/req_value and are taken when start is high
// and busy is low. Matrix words (kind 0) load row-major, one per cycle; after
// the n*n-th word the block factors the matrix and emits one status word.
// Right-hand-side words (kind 1) load one per cycle while factors are valid
// (else each draws a NOFACTOR status word); after the n-th word the block
// substitutes and emits n solution words on consecutive cycles.
// Each result is on rsp_* for one cycle with rsp_valid high; the receiver
// cannot stall, so results are never held back. Each multiply-accumulate runs
// through S_MRD, S_MUL and S_ACC, and each of the n*(n-1)/2 divides of
// factoring passes through the 48-cell divider chain, one at a time; a solve
// uses the same path and divider. The order n is written over the APB port
// at byte address 0; the user must write it only while idle, which the block
// does not enforce. A write drops any partial load and the current factors.
// Reset (synchronous) clears the load counts and the valid factors and sets
// n to 8 (MAX_ORDER if smaller); the matrix store holds no data until loaded.
// ----------------------------------------------------------------------------
module lu_decompose_and_solve #(
   parameter int MAX_ORDER = lds_pkg::MAX_ORDER_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_kind,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   output logic        rsp_result_kind,
   output logic [1:0]  rsp_status,
   output logic        rsp_parity_negative,
   output logic [31:0] rsp_value_res,
   output logic        rsp_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int CW = $clog2(MAX_ORDER + 1);
   localparam int AW = $clog2(MAX_ORDER);
   localparam int MW = $clog2(MAX_ORDER * MAX_ORDER);
   localparam int ACC_W = lds_pkg::ACC_W;
   localparam int ORDER_RESET = (lds_pkg::ORDER_DEF > MAX_ORDER) ? MAX_ORDER : lds_pkg::ORDER_DEF;

   typedef enum logic [5:0] {
      S_IDLE, S_SC_RD, S_SC_USE, S_COL, S_INIT, S_INIT_USE, S_MRD, S_MUL, S_ACC,
      S_STORE, S_CP1, S_CP2, S_CP3, S_LNEXT, S_SW_RD, S_SW_W1, S_SW_W2, S_SW_DONE,
      S_PIVW, S_PIV_RD, S_PIV_USE, S_D_RD, S_D_GO, S_D_WAIT, S_COLEND, S_DEC_END,
      S_FW_A, S_FW_B, S_FW_ST, S_BK_A, S_BK_ST, S_BK_GO, S_OUT
   } state_type;

   typedef enum logic [1:0] {PH_DEC, PH_FWD, PH_BWD} phase_type;

   function automatic logic [MW-1:0] at_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
      return MW'(int'(r) * MAX_ORDER + int'(c));
   endfunction

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
      if (v > $signed(ACC_W'(32'h7fff_ffff))) begin
         return 32'h7fff_ffff;
      end else if (v < -$signed(ACC_W'(33'h1_0000_0000 >> 1))) begin
         return 32'h8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

   function automatic logic signed [ACC_W-1:0] sext(input logic [31:0] v);
      return $signed({{(ACC_W-32){v[31]}}, v});
   endfunction

   state_type state_ff, state_in;
   phase_type ph_ff, ph_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in, kend_ff, kend_in, best_ff, best_in;
   logic [CW-1:0] ldr_ff, ldr_in, ldc_ff, ldc_in, vc_ff, vc_in;
   logic [AW-1:0] ip_ff, ip_in;
   logic [31:0] big_ff, big_in, bestmag_ff, bestmag_in, m_ff, m_in;
   logic [31:0] piv_ff, piv_in, bk_ff, bk_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic [63:0] prod_ff, prod_in, x_ff, x_in, y_ff, y_in;
   logic pneg_ff, pneg_in, fv_ff, fv_in, par_ff, par_in;
   logic [3:0] order_ff, order_in;
   logic [31:0] scale_ff [MAX_ORDER];
   logic [31:0] scale_in [MAX_ORDER];
   logic [AW-1:0] pivr_ff [MAX_ORDER];
   logic [AW-1:0] pivr_in [MAX_ORDER];
   logic [31:0] wv_ff [MAX_ORDER];
   logic [31:0] wv_in [MAX_ORDER];
   logic rv_ff, rv_in, rk_ff, rk_in, rpar_ff, rpar_in, rlast_ff, rlast_in;
   logic [1:0] rst_ff, rst_in;
   logic [31:0] rval_ff, rval_in;

   logic [31:0] lu_mem [MAX_ORDER * MAX_ORDER];
   logic [31:0] rda_ff, rdb_ff;
   logic          mem_re, mem_we;
   logic [MW-1:0] ra, rb, mem_wa;
   logic [31:0]   mem_wd;

   logic          div_go, div_done;
   logic [31:0]   div_a, div_p, div_q;

   logic [CW-1:0] n_c, sc_sel, wv_sel, kk, ipc;
   logic [31:0]   scale_rd, wv_rd, opb, bnx, sv;
   logic [63:0]   rnd;
   logic signed [ACC_W-1:0] rext;
   logic          wr_en;
   logic [3:0]    wr_v;

   lds_divider u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .a     (div_a),
      .p     (div_p),
      .q     (div_q),
      .done  (div_done)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         lu_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rda_ff <= lu_mem[ra];
         rdb_ff <= lu_mem[rb];
      end
   end

   assign n_c      = CW'(order_ff);
   assign scale_rd = scale_ff[sc_sel[AW-1:0]];
   assign wv_rd    = wv_ff[wv_sel[AW-1:0]];
   assign wr_en    = psel & penable & pwrite & ~paddr[2];
   assign wr_v     = pwdata[3:0];
   assign pready   = 1'b1;
   assign prdata   = paddr[2] ? 32'd0 : {28'd0, order_ff};
   assign busy     = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;  ph_in = ph_ff;
      i_in = i_ff;  j_in = j_ff;  k_in = k_ff;  kend_in = kend_ff;  best_in = best_ff;
      ldr_in = ldr_ff;  ldc_in = ldc_ff;  vc_in = vc_ff;  ip_in = ip_ff;
      big_in = big_ff;  bestmag_in = bestmag_ff;  m_in = m_ff;
      piv_in = piv_ff;  bk_in = bk_ff;  acc_in = acc_ff;
      prod_in = prod_ff;  x_in = x_ff;  y_in = y_ff;  pneg_in = pneg_ff;
      fv_in = fv_ff;  par_in = par_ff;  order_in = order_ff;
      scale_in = scale_ff;  pivr_in = pivr_ff;  wv_in = wv_ff;
      rv_in = 1'b0;  rk_in = rk_ff;  rst_in = rst_ff;  rpar_in = rpar_ff;
      rval_in = rval_ff;  rlast_in = rlast_ff;
      mem_re = 1'b0;  mem_we = 1'b0;  ra = at_addr(i_ff, j_ff);  rb = at_addr(k_ff, j_ff);
      mem_wa = at_addr(i_ff, j_ff);  mem_wd = 32'd0;
      div_go = 1'b0;  div_a = rda_ff;  div_p = piv_ff;
      sc_sel = i_ff;  wv_sel = i_ff;
      kk  = (i_ff < j_ff) ? i_ff : j_ff;
      ipc = CW'(pivr_ff[i_ff[AW-1:0]]);
      if (ipc >= n_c) begin
         ipc = i_ff;
      end
      bnx  = (mag32(rda_ff) > big_ff) ? mag32(rda_ff) : big_ff;
      sv   = sat32(acc_ff);
      opb  = (ph_ff == PH_DEC) ? rdb_ff : wv_rd;
      rnd  = prod_ff + 64'h8000;
      rext = $signed({{(ACC_W-48){1'b0}}, rnd[63:16]});

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_kind == lds_pkg::KIND_MATRIX) begin
                  mem_we = 1'b1;
                  mem_wa = at_addr(ldr_ff, ldc_ff);
                  mem_wd = req_value;
                  fv_in  = 1'b0;
                  vc_in  = '0;
                  if (ldc_ff + 1'b1 == n_c) begin
                     ldc_in = '0;
                     if (ldr_ff + 1'b1 == n_c) begin
                        ldr_in = '0;  i_in = '0;  j_in = '0;  big_in = 32'd0;
                        ph_in = PH_DEC;
                        state_in = S_SC_RD;
                     end else begin
                        ldr_in = ldr_ff + 1'b1;
                     end
                  end else begin
                     ldc_in = ldc_ff + 1'b1;
                  end
               end else if (!fv_ff) begin
                  rv_in = 1'b1;  rk_in = lds_pkg::RK_STATUS;  rst_in = lds_pkg::STATUS_NOFACTOR;
                  rpar_in = 1'b0;  rval_in = 32'd0;  rlast_in = 1'b1;
               end else begin
                  wv_in[vc_ff[AW-1:0]] = req_value;
                  if (vc_ff + 1'b1 == n_c) begin
                     vc_in = '0;  i_in = '0;  ph_in = PH_FWD;
                     state_in = S_FW_A;
                  end else begin
                     vc_in = vc_ff + 1'b1;
                  end
               end
            end
         end
         S_SC_RD: begin
            mem_re = 1'b1;
            state_in = S_SC_USE;
         end
         S_SC_USE: begin
            if (j_ff + 1'b1 < n_c) begin
               big_in = bnx;  j_in = j_ff + 1'b1;
               state_in = S_SC_RD;
            end else if (bnx == 32'd0) begin
               rv_in = 1'b1;  rk_in = lds_pkg::RK_STATUS;  rst_in = lds_pkg::STATUS_SINGULAR;
               rpar_in = 1'b0;  rval_in = 32'd0;  rlast_in = 1'b1;
               par_in = 1'b0;  fv_in = 1'b0;
               state_in = S_IDLE;
            end else begin
               scale_in[i_ff[AW-1:0]] = bnx;
               big_in = 32'd0;  j_in = '0;
               if (i_ff + 1'b1 < n_c) begin
                  i_in = i_ff + 1'b1;
                  state_in = S_SC_RD;
               end else begin
                  par_in = 1'b0;  i_in = '0;
                  state_in = S_COL;
               end
            end
         end
         S_COL: begin
            i_in = '0;
            state_in = S_INIT;
         end
         S_INIT: begin
            mem_re = 1'b1;
            state_in = S_INIT_USE;
         end
         S_INIT_USE: begin
            acc_in = sext(rda_ff);  k_in = '0;  kend_in = kk;
            state_in = (kk != '0) ? S_MRD : S_STORE;
         end
         S_MRD: begin
            mem_re = 1'b1;
            ra = at_addr(i_ff, k_ff);
            state_in = S_MUL;
         end
         S_MUL: begin
            wv_sel  = k_ff;
            prod_in = mag32(rda_ff) * mag32(opb);
            pneg_in = rda_ff[31] ^ opb[31];
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in = pneg_ff ? (acc_ff + rext) : (acc_ff - rext);
            if (k_ff + 1'b1 < kend_ff) begin
               k_in = k_ff + 1'b1;
               state_in = S_MRD;
            end else begin
               case (ph_ff)
                  PH_FWD:  state_in = S_FW_ST;
                  PH_BWD:  state_in = S_BK_ST;
                  default: state_in = S_STORE;
               endcase
            end
         end
         S_STORE: begin
            mem_we = 1'b1;  mem_wd = sv;
            if (i_ff < j_ff) begin
               i_in = i_ff + 1'b1;
               state_in = S_INIT;
            end else begin
               m_in = mag32(sv);
               if (i_ff == j_ff) begin
                  best_in = i_ff;  bestmag_in = mag32(sv);
                  state_in = S_LNEXT;
               end else begin
                  state_in = S_CP1;
               end
            end
         end
         S_CP1: begin
            sc_sel = best_ff;
            x_in = m_ff * scale_rd;
            state_in = S_CP2;
         end
         S_CP2: begin
            y_in = bestmag_ff * scale_rd;
            state_in = S_CP3;
         end
         S_CP3: begin
            if (x_ff >= y_ff) begin
               best_in = i_ff;  bestmag_in = m_ff;
            end
            state_in = S_LNEXT;
         end
         S_LNEXT: begin
            k_in = '0;
            if (i_ff + 1'b1 < n_c) begin
               i_in = i_ff + 1'b1;
               state_in = S_INIT;
            end else begin
               state_in = (best_ff != j_ff) ? S_SW_RD : S_PIVW;
            end
         end
         S_SW_RD: begin
            mem_re = 1'b1;
            ra = at_addr(best_ff, k_ff);
            rb = at_addr(j_ff, k_ff);
            state_in = S_SW_W1;
         end
         S_SW_W1: begin
            mem_we = 1'b1;  mem_wa = at_addr(best_ff, k_ff);  mem_wd = rdb_ff;
            state_in = S_SW_W2;
         end
         S_SW_W2: begin
            mem_we = 1'b1;  mem_wa = at_addr(j_ff, k_ff);  mem_wd = rda_ff;
            if (k_ff + 1'b1 < n_c) begin
               k_in = k_ff + 1'b1;
               state_in = S_SW_RD;
            end else begin
               state_in = S_SW_DONE;
            end
         end
         S_SW_DONE: begin
            sc_sel = j_ff;
            scale_in[best_ff[AW-1:0]] = scale_rd;
            par_in = ~par_ff;
            state_in = S_PIVW;
         end
         S_PIVW: begin
            pivr_in[j_ff[AW-1:0]] = best_ff[AW-1:0];
            state_in = S_PIV_RD;
         end
         S_PIV_RD: begin
            mem_re = 1'b1;
            ra = at_addr(j_ff, j_ff);
            state_in = S_PIV_USE;
         end
         S_PIV_USE: begin
            if (rda_ff == 32'd0) begin
               mem_we = 1'b1;  mem_wa = at_addr(j_ff, j_ff);  mem_wd = 32'd1;
               piv_in = 32'd1;
            end else begin
               piv_in = rda_ff;
            end
            i_in = j_ff + 1'b1;
            state_in = (j_ff + 1'b1 < n_c) ? S_D_RD : S_COLEND;
         end
         S_D_RD: begin
            mem_re = 1'b1;
            state_in = S_D_GO;
         end
         S_D_GO: begin
            div_go = 1'b1;
            state_in = S_D_WAIT;
         end
         S_D_WAIT: begin
            if (div_done) begin
               if (ph_ff == PH_DEC) begin
                  mem_we = 1'b1;  mem_wd = div_q;
                  if (i_ff + 1'b1 < n_c) begin
                     i_in = i_ff + 1'b1;
                     state_in = S_D_RD;
                  end else begin
                     state_in = S_COLEND;
                  end
               end else begin
                  wv_in[i_ff[AW-1:0]] = div_q;
                  if (i_ff == '0) begin
                     state_in = S_OUT;
                  end else begin
                     i_in = i_ff - 1'b1;
                     state_in = S_BK_A;
                  end
               end
            end
         end
         S_COLEND: begin
            if (j_ff + 1'b1 < n_c) begin
               j_in = j_ff + 1'b1;
               state_in = S_COL;
            end else begin
               state_in = S_DEC_END;
            end
         end
         S_DEC_END: begin
            rv_in = 1'b1;  rk_in = lds_pkg::RK_STATUS;  rst_in = lds_pkg::STATUS_OK;
            rpar_in = par_ff;  rval_in = 32'd0;  rlast_in = 1'b1;
            fv_in = 1'b1;
            state_in = S_IDLE;
         end
         S_FW_A: begin
            wv_sel = ipc;
            acc_in = sext(wv_rd);
            ip_in  = ipc[AW-1:0];
            state_in = S_FW_B;
         end
         S_FW_B: begin
            wv_in[ip_ff] = wv_rd;
            k_in = '0;  kend_in = i_ff;
            state_in = (i_ff != '0) ? S_MRD : S_FW_ST;
         end
         S_FW_ST: begin
            wv_in[i_ff[AW-1:0]] = sv;
            if (i_ff + 1'b1 < n_c) begin
               i_in = i_ff + 1'b1;
               state_in = S_FW_A;
            end else begin
               i_in = n_c - 1'b1;  ph_in = PH_BWD;
               state_in = S_BK_A;
            end
         end
         S_BK_A: begin
            acc_in = sext(wv_rd);
            k_in = i_ff + 1'b1;  kend_in = n_c;
            state_in = (i_ff + 1'b1 < n_c) ? S_MRD : S_BK_ST;
         end
         S_BK_ST: begin
            bk_in  = sv;
            mem_re = 1'b1;
            ra = at_addr(i_ff, i_ff);
            state_in = S_BK_GO;
         end
         S_BK_GO: begin
            div_go = 1'b1;  div_a = bk_ff;  div_p = rda_ff;
            state_in = S_D_WAIT;
         end
         S_OUT: begin
            rv_in = 1'b1;  rk_in = lds_pkg::RK_SOLUTION;  rst_in = lds_pkg::STATUS_OK;
            rpar_in = par_ff;  rval_in = wv_rd;  rlast_in = (i_ff + 1'b1 == n_c);
            if (i_ff + 1'b1 == n_c) begin
               state_in = S_IDLE;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (wr_en) begin
         if (wr_v == 4'd0) begin
            order_in = 4'd1;
         end else if (int'(wr_v) > MAX_ORDER) begin
            order_in = 4'(MAX_ORDER);
         end else begin
            order_in = wr_v;
         end
         ldr_in = '0;  ldc_in = '0;  vc_in = '0;  fv_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ldr_ff   <= '0;
         ldc_ff   <= '0;
         vc_ff    <= '0;
         fv_ff    <= 1'b0;
         par_ff   <= 1'b0;
         order_ff <= 4'(ORDER_RESET);
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ldr_ff   <= ldr_in;
         ldc_ff   <= ldc_in;
         vc_ff    <= vc_in;
         fv_ff    <= fv_in;
         par_ff   <= par_in;
         order_ff <= order_in;
         rv_ff    <= rv_in;
      end
      ph_ff <= ph_in;  i_ff <= i_in;  j_ff <= j_in;  k_ff <= k_in;
      kend_ff <= kend_in;  best_ff <= best_in;  ip_ff <= ip_in;
      big_ff <= big_in;  bestmag_ff <= bestmag_in;  m_ff <= m_in;
      piv_ff <= piv_in;  bk_ff <= bk_in;  acc_ff <= acc_in;
      prod_ff <= prod_in;  x_ff <= x_in;  y_ff <= y_in;  pneg_ff <= pneg_in;
      scale_ff <= scale_in;  pivr_ff <= pivr_in;  wv_ff <= wv_in;
      rk_ff <= rk_in;  rst_ff <= rst_in;  rpar_ff <= rpar_in;
      rval_ff <= rval_in;  rlast_ff <= rlast_in;
   end

   assign rsp_valid           = rv_ff;
   assign rsp_result_kind     = rk_ff;
   assign rsp_status          = rst_ff;
   assign rsp_parity_negative = rpar_ff;
   assign rsp_value_res       = rval_ff;
   assign rsp_last            = rlast_ff;

endmodule

// ===== rtl/lds_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lds_checker
// Port-level checks of the LU decompose and solve block.
// ----------------------------------------------------------------------------
module lds_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_kind,
   input logic        rsp_valid,
   input logic        rsp_result_kind,
   input logic [1:0]  rsp_status,
   input logic        rsp_parity_negative,
   input logic [31:0] rsp_value_res,
   input logic        rsp_last
);

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == lds_pkg::RK_STATUS |-> rsp_last)
      else $error("status word without last");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == lds_pkg::RK_STATUS |-> rsp_value_res == 32'd0)
      else $error("status word with nonzero value");

   a_bad_parity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != lds_pkg::STATUS_OK |-> !rsp_parity_negative)
      else $error("parity set on failing status");

   a_matrix_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_kind == lds_pkg::KIND_MATRIX |=> !rsp_valid)
      else $error("result right after a matrix word");

endmodule

bind lu_decompose_and_solve lds_checker u_lds_checker (
   .clock               (clock),
   .reset               (reset),
   .start               (start),
   .busy                (busy),
   .req_kind            (req_kind),
   .rsp_valid           (rsp_valid),
   .rsp_result_kind     (rsp_result_kind),
   .rsp_status          (rsp_status),
   .rsp_parity_negative (rsp_parity_negative),
   .rsp_value_res       (rsp_value_res),
   .rsp_last            (rsp_last)
);
